>>> rtl/ac_ir_frame_encoder_defines.svh
// Assertion helpers for the encoder modules, included by the back-end sequencer.
`ifndef AC_IR_FRAME_ENCODER_DEFINES_SVH
`define AC_IR_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ACIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ACIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/acir_pkg.sv
`default_nettype none

package acir_pkg;

    localparam int FRAME_W     = 48;
    localparam int TIME_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int RES_W       = 6;
    localparam int SYM_W       = 7;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [RES_W-1:0] LAST_RESULT = RES_W'(49);
    localparam logic [SYM_W-1:0] LAST_DATA_SYM = SYM_W'(96);
    localparam logic [SYM_W-1:0] FOOTER_SYM = SYM_W'(97);

    localparam logic [FRAME_W-1:0] FRAME_BASE = 48'hD5_0000_0000_00;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 3'd4;

    localparam logic [TIME_W-1:0] HEADER_MARK_RST  = 16'd6820;
    localparam logic [TIME_W-1:0] HEADER_SPACE_RST = 16'd6820;
    localparam logic [TIME_W-1:0] BIT_MARK_RST     = 16'd580;
    localparam logic [TIME_W-1:0] ONE_SPACE_RST    = 16'd580;
    localparam logic [TIME_W-1:0] ZERO_SPACE_RST   = 16'd1860;

    typedef struct packed {
        logic [TIME_W-1:0] header_mark;
        logic [TIME_W-1:0] header_space;
        logic [TIME_W-1:0] bit_mark;
        logic [TIME_W-1:0] one_space;
        logic [TIME_W-1:0] zero_space;
    } t_timing;

    typedef struct packed {
        logic [TIME_W-1:0] mark;
        logic [TIME_W-1:0] space;
    } t_symbol;

    // Mark and space of symbol k of the train for one frame
    function automatic t_symbol symbol_at(input logic [FRAME_W-1:0] frame,
                                          input logic [SYM_W-1:0] k,
                                          input t_timing tm);
        t_symbol          s;
        logic [SYM_W-1:0] idx;
        logic [7:0]       byte_val;
        logic             bit_v;
        idx = k - SYM_W'(1);
        case (idx[6:4])
            3'd0:    byte_val = frame[7:0];
            3'd1:    byte_val = frame[15:8];
            3'd2:    byte_val = frame[23:16];
            3'd3:    byte_val = frame[31:24];
            3'd4:    byte_val = frame[39:32];
            default: byte_val = frame[47:40];
        endcase
        // Second half of each byte group sends the inverse
        bit_v = byte_val[idx[2:0]] ^ idx[3];
        if (k == '0) begin
            s.mark  = tm.header_mark;
            s.space = tm.header_space;
        end else if (k <= LAST_DATA_SYM) begin
            s.mark  = tm.bit_mark;
            s.space = bit_v ? tm.one_space : tm.zero_space;
        end else if (k == FOOTER_SYM) begin
            s.mark  = tm.bit_mark;
            s.space = tm.header_space;
        end else begin
            s.mark  = tm.bit_mark;
            s.space = '0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/acir_front.sv
`default_nettype none

module acir_front import acir_pkg::*; (
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [3:0]         i_command,
    input  wire logic               i_light_on,
    input  wire logic               i_turbo_on,
    input  wire logic               i_sleep_on,
    input  wire logic               i_power_on,
    input  wire logic [1:0]         i_swing_setting,
    input  wire logic [1:0]         i_fan_speed,
    input  wire logic [7:0]         i_temperature_c,
    input  wire logic [2:0]         i_mode,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output logic [FRAME_W-1:0]      o_frame
);

    logic [3:0] w_temp;

    // Clamp temperature to 16..31 and store it minus 16
    always_comb begin
        if (i_temperature_c < 8'd16) begin
            w_temp = 4'd0;
        end else if (i_temperature_c > 8'd31) begin
            w_temp = 4'd15;
        end else begin
            w_temp = i_temperature_c[3:0];
        end
    end

    // Pack the setting over the base pattern
    always_comb begin
        o_frame        = FRAME_BASE;
        o_frame[19:16] = i_command;
        o_frame[8]     = i_light_on;
        o_frame[11]    = i_turbo_on;
        o_frame[24]    = i_sleep_on;
        o_frame[25]    = i_power_on;
        o_frame[27:26] = i_swing_setting;
        o_frame[30:29] = i_fan_speed;
        o_frame[35:32] = w_temp;
        o_frame[39:37] = i_mode;
    end

    // Accept a transfer whenever the queue has room
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

`default_nettype wire

>>> rtl/acir_queue.sv
`default_nettype none

module acir_queue import acir_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [FRAME_W-1:0] i_frame,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output logic [FRAME_W-1:0]      o_frame
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [FRAME_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

`default_nettype wire

>>> rtl/acir_back.sv
`default_nettype none

`include "ac_ir_frame_encoder_defines.svh"

module acir_back import acir_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_timing            i_timing,
    input  wire logic               i_frame_valid,
    input  wire logic [FRAME_W-1:0] i_frame,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [TIME_W-1:0]       o_first_mark_us,
    output logic [TIME_W-1:0]       o_first_space_us,
    output logic [TIME_W-1:0]       o_second_mark_us,
    output logic [TIME_W-1:0]       o_second_space_us,
    output logic                    o_second_valid,
    output logic                    o_last
);

    logic               r_busy;
    logic [FRAME_W-1:0] r_frame;
    logic [RES_W-1:0]   r_res;
    logic               w_adv;
    logic               w_final;
    t_symbol            w_sym0;
    t_symbol            w_sym1;

    assign w_adv   = !o_valid || !i_stall;
    assign w_final = (r_res == LAST_RESULT);
    assign o_pop   = w_adv && i_frame_valid && (!r_busy || w_final);

    // Two symbols per result
    assign w_sym0 = symbol_at(r_frame, {r_res, 1'b0}, i_timing);
    assign w_sym1 = symbol_at(r_frame, {r_res, 1'b1}, i_timing);

    // Sequence results; take the next frame as the last result goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_res   <= '0;
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= r_busy;
            if (o_pop) begin
                r_busy <= 1'b1;
                r_res  <= '0;
            end else if (r_busy && w_final) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_res  <= r_res + RES_W'(1);
            end
        end
    end

    // Load frame and output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= i_frame;
        end
        if (w_adv && r_busy) begin
            o_first_mark_us   <= w_sym0.mark;
            o_first_space_us  <= w_sym0.space;
            o_second_mark_us  <= w_final ? '0 : w_sym1.mark;
            o_second_space_us <= w_final ? '0 : w_sym1.space;
            o_second_valid    <= !w_final;
            o_last            <= w_final;
        end
    end

    `ACIR_ASSERT_NOW(a_res_range, r_busy, r_res <= LAST_RESULT, "result index past end")
    `ACIR_ASSERT_NOW(a_pop_valid, o_pop, i_frame_valid, "pop from empty queue")
    `ACIR_ASSERT_NEXT(a_idle_after_last, w_adv && r_busy && w_final && !i_frame_valid,
                      !r_busy && o_valid && o_last, "sequencer did not finish frame")

endmodule

`default_nettype wire

>>> rtl/ac_ir_frame_encoder.sv
// The first result of a setting is registered after its transfer passes the queue write,
//   the sequencer load and the output register, when the queue and sequencer are idle.
// The back-end sequencer gives one result per cycle while i_stall is low, 50 results per
//   setting; a queued setting is loaded as the previous setting's last result is registered.
// Reset: synchronous active-low; clears the queue and sequencer, loads default timings.
`default_nettype none

module ac_ir_frame_encoder import acir_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TIME_W-1:0]    i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [3:0]           i_command,
    input  wire logic                 i_light_on,
    input  wire logic                 i_turbo_on,
    input  wire logic                 i_sleep_on,
    input  wire logic                 i_power_on,
    input  wire logic [1:0]           i_swing_setting,
    input  wire logic [1:0]           i_fan_speed,
    input  wire logic [7:0]           i_temperature_c,
    input  wire logic [2:0]           i_mode,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [TIME_W-1:0]         o_first_mark_us,
    output logic [TIME_W-1:0]         o_first_space_us,
    output logic [TIME_W-1:0]         o_second_mark_us,
    output logic [TIME_W-1:0]         o_second_space_us,
    output logic                      o_second_valid,
    output logic                      o_last
);

    t_timing            r_timing;
    logic               w_q_full;
    logic               w_push;
    logic [FRAME_W-1:0] w_push_frame;
    logic               w_pop;
    logic               w_q_valid;
    logic [FRAME_W-1:0] w_q_frame;

    assign o_cfg_ready = 1'b1;

    // Timing registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.header_mark  <= HEADER_MARK_RST;
            r_timing.header_space <= HEADER_SPACE_RST;
            r_timing.bit_mark     <= BIT_MARK_RST;
            r_timing.one_space    <= ONE_SPACE_RST;
            r_timing.zero_space   <= ZERO_SPACE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HEADER_MARK:  r_timing.header_mark  <= i_cfg_data;
                CFG_HEADER_SPACE: r_timing.header_space <= i_cfg_data;
                CFG_BIT_MARK:     r_timing.bit_mark     <= i_cfg_data;
                CFG_ONE_SPACE:    r_timing.one_space    <= i_cfg_data;
                CFG_ZERO_SPACE:   r_timing.zero_space   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    acir_front u_front (
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_light_on      (i_light_on),
        .i_turbo_on      (i_turbo_on),
        .i_sleep_on      (i_sleep_on),
        .i_power_on      (i_power_on),
        .i_swing_setting (i_swing_setting),
        .i_fan_speed     (i_fan_speed),
        .i_temperature_c (i_temperature_c),
        .i_mode          (i_mode),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_frame         (w_push_frame)
    );

    acir_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_push_frame),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_frame (w_q_frame)
    );

    acir_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_timing          (r_timing),
        .i_frame_valid     (w_q_valid),
        .i_frame           (w_q_frame),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_first_mark_us   (o_first_mark_us),
        .o_first_space_us  (o_first_space_us),
        .o_second_mark_us  (o_second_mark_us),
        .o_second_space_us (o_second_space_us),
        .o_second_valid    (o_second_valid),
        .o_last            (o_last)
    );

endmodule

`default_nettype wire
